### hdl/mpq_pkg.sv
// Shared constants, types and codes of the min priority queue.
package mpq_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int KEY_BITS_DEF = 16;
  localparam int OUT_KEY_BITS = 16;
  localparam int COUNT_OUT_BITS = 7;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_DELETE = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic insert;
    logic shift_down;
  } cell_ctl_t;

endpackage

### hdl/mpq_if.sv
// Request and response channel interfaces of the min priority queue.
interface mpq_req_if #(
  parameter int KEY_BITS = mpq_pkg::KEY_BITS_DEF
) ();
  logic                valid;
  logic                ready;
  logic                kind;
  logic [KEY_BITS-1:0] key;

  modport source (output valid, kind, key, input ready);
  modport sink (input valid, kind, key, output ready);
endinterface

interface mpq_rsp_if ();
  logic                                valid;
  logic                                ready;
  logic [1:0]                          status;
  logic [mpq_pkg::OUT_KEY_BITS-1:0]    removed_key;
  logic [mpq_pkg::OUT_KEY_BITS-1:0]    min_key;
  logic                                min_valid;
  logic [mpq_pkg::COUNT_OUT_BITS-1:0]  entry_count;

  modport source (output valid, status, removed_key, min_key, min_valid, entry_count,
                  input ready);
  modport sink (input valid, status, removed_key, min_key, min_valid, entry_count,
                output ready);
endinterface

### hdl/mpq_cell.sv
// One cell of the sorted key chain: holds a key, shifts up on insert, down on delete.
module mpq_cell #(
  parameter int KEY_BITS = mpq_pkg::KEY_BITS_DEF
) (
  input  logic                clk,
  input  mpq_pkg::cell_ctl_t  ctl,
  input  logic [KEY_BITS-1:0] new_key,
  input  logic                occ,
  input  logic [KEY_BITS-1:0] left_key,
  input  logic                left_bump,
  input  logic [KEY_BITS-1:0] right_key,
  output logic [KEY_BITS-1:0] key,
  output logic                bump
);
  import mpq_pkg::*;

  logic [KEY_BITS-1:0] key_next;

  assign bump = occ && (new_key < key);

  always_comb begin
    key_next = key;
    if (ctl.insert) begin
      if (left_bump) begin
        key_next = left_key;
      end else if (bump || !occ) begin
        key_next = new_key;
      end
    end else if (ctl.shift_down) begin
      key_next = right_key;
    end
  end

  always_ff @(posedge clk) begin
    key <= key_next;
  end

endmodule

### hdl/min_priority_queue_unit.sv
// Top level of the min priority queue: a sorted chain of key cells and a result register.
// Latency: a result is valid in the cycle after its request transaction.
// Throughput: one request per cycle while the response side takes results; the cells
// that shift or load all do so in parallel, so the chain length does not add cycles.
// Reset clears the entry count and the response valid; cell keys are not reset.
module min_priority_queue_unit #(
  parameter int CAPACITY = mpq_pkg::CAPACITY_DEF,
  parameter int KEY_BITS = mpq_pkg::KEY_BITS_DEF
) (
  input logic clk,
  input logic rst,
  mpq_req_if.sink   req,
  mpq_rsp_if.source rsp
);
  import mpq_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  logic [CW-1:0]       count;
  logic [CW-1:0]       count_next;
  logic [KEY_BITS-1:0] cell_key [CAPACITY];
  logic                cell_bump [CAPACITY];
  logic                cell_occ [CAPACITY];
  cell_ctl_t           ctl;
  logic                take;
  logic                is_full;
  logic                is_empty;

  logic                rsp_valid;
  status_t             status;
  status_t             status_next;
  logic [KEY_BITS-1:0] removed;
  logic [KEY_BITS-1:0] removed_next;
  logic [KEY_BITS-1:0] min_key;
  logic [KEY_BITS-1:0] min_key_next;
  logic                min_valid;
  logic                min_valid_next;

  assign req.ready = !rsp_valid || rsp.ready;
  assign take      = req.valid && req.ready;
  assign is_full   = count == CW'(CAPACITY);
  assign is_empty  = count == '0;

  always_comb begin
    ctl.insert     = take && (req.kind == KIND_INSERT) && !is_full;
    ctl.shift_down = take && (req.kind == KIND_DELETE) && !is_empty;
  end

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      assign cell_occ[i] = count > CW'(i);
      mpq_cell #(.KEY_BITS(KEY_BITS)) u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .new_key   (req.key),
        .occ       (cell_occ[i]),
        .left_key  ((i == 0) ? cell_key[0] : cell_key[(i == 0) ? 0 : i - 1]),
        .left_bump ((i == 0) ? 1'b0 : cell_bump[(i == 0) ? 0 : i - 1]),
        .right_key (cell_key[(i == CAPACITY - 1) ? i : i + 1]),
        .key       (cell_key[i]),
        .bump      (cell_bump[i])
      );
    end
  endgenerate

  always_comb begin
    count_next     = count;
    status_next    = STATUS_OK;
    removed_next   = '0;
    min_key_next   = cell_key[0];
    min_valid_next = !is_empty;
    if (req.kind == KIND_INSERT) begin
      if (is_full) begin
        status_next = STATUS_FULL;
      end else begin
        count_next     = count + CW'(1);
        min_valid_next = 1'b1;
        if (is_empty || req.key < cell_key[0]) begin
          min_key_next = req.key;
        end
      end
    end else begin
      if (is_empty) begin
        status_next  = STATUS_EMPTY;
        min_key_next = '0;
      end else begin
        count_next     = count - CW'(1);
        removed_next   = cell_key[0];
        min_valid_next = count > CW'(1);
        min_key_next   = (count > CW'(1)) ? cell_key[1] : '0;
      end
    end
    if (!min_valid_next) begin
      min_key_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (take) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      status    <= status_next;
      removed   <= removed_next;
      min_key   <= min_key_next;
      min_valid <= min_valid_next;
    end
  end

  assign rsp.valid     = rsp_valid;
  assign rsp.status    = status;
  assign rsp.min_valid = min_valid;

  generate
    if (KEY_BITS >= OUT_KEY_BITS) begin : g_out_cut
      assign rsp.removed_key = removed[OUT_KEY_BITS-1:0];
      assign rsp.min_key     = min_key[OUT_KEY_BITS-1:0];
    end else begin : g_out_ext
      assign rsp.removed_key = {{(OUT_KEY_BITS - KEY_BITS){1'b0}}, removed};
      assign rsp.min_key     = {{(OUT_KEY_BITS - KEY_BITS){1'b0}}, min_key};
    end
    if (CW >= COUNT_OUT_BITS) begin : g_cnt_cut
      assign rsp.entry_count = count[COUNT_OUT_BITS-1:0];
    end else begin : g_cnt_ext
      assign rsp.entry_count = {{(COUNT_OUT_BITS - CW){1'b0}}, count};
    end
  endgenerate

endmodule
